// ===== rtl/glu_pkg.sv =====
// Package for the gcd/lcm unit: operand width, counter width and sequencer states.
`timescale 1ns / 1ps

package glu_pkg;

  // Operand width in bits; the result ports share it.
  localparam int unsigned Width = 16;

  // Counter width: enough to count Width - 1 down to zero.
  localparam int unsigned CntW = $clog2(Width);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SCALE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/gcd_lcm_unit.sv =====
// Top level of the gcd/lcm unit: binary gcd, serial divide and serial multiply.
`timescale 1ns / 1ps

//  Channel   Direction  Ports                                         Handshake
//  request   in         value_a_i, value_b_i                          start high, busy low
//  result    out        gcd_out_o, lcm_out_o, lcm_overflow_o          result_valid_o, 1 cycle
//
//  A request runs through the gcd steps (one shift or one subtract-and-shift per cycle), the
//  restoring of the common factors of two, the divide and the multiply. The lcm quotient comes
//  from a one-bit-per-cycle restoring divider and the product from a one-bit-per-cycle
//  shift-add multiplier; either operand zero skips both.
//  busy stays high from acceptance until the cycle after the result strobe.
//  The result is shown for exactly one cycle; the receiver cannot stall it.
//  Reset (rst_ni, asynchronous, active low) returns the sequencer to idle.

module gcd_lcm_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [glu_pkg::Width-1:0] value_a_i,
  input  logic [glu_pkg::Width-1:0] value_b_i,
  output logic                     result_valid_o,
  output logic [glu_pkg::Width-1:0] gcd_out_o,
  output logic [glu_pkg::Width-1:0] lcm_out_o,
  output logic                     lcm_overflow_o
);

  localparam int unsigned W = glu_pkg::Width;
  localparam int unsigned C = glu_pkg::CntW;
  localparam logic [C-1:0] CntLast = C'(W - 1);

  glu_pkg::state_e state_q, state_d;

  logic [W-1:0] a_q;     // operand a, then quotient a / g, then low product half
  logic [W-1:0] b_q;     // operand b
  logic [W-1:0] x_q;     // gcd working values
  logic [W-1:0] y_q;
  logic [W-1:0] g_q;     // odd part of the gcd, then the gcd itself
  logic [C-1:0] k_q;     // common factors of two
  logic [C-1:0] cnt_q;   // bit counter for divide and multiply
  logic [W-1:0] rem_q;   // partial remainder
  logic [W-1:0] hi_q;    // high product half
  logic         zero_q;  // an operand was zero

  logic         accept;
  logic         gcd_end;
  logic [W:0]   diff_xy;
  logic [W:0]   diff_yx;
  logic [W:0]   div_sh;
  logic [W+1:0] div_tr;
  logic [W:0]   mul_sum;

  assign accept  = start && !busy;
  assign gcd_end = (x_q == '0) || (y_q == '0);
  assign diff_xy = {1'b0, x_q} - {1'b0, y_q};
  assign diff_yx = {1'b0, y_q} - {1'b0, x_q};
  assign div_sh  = {rem_q, a_q[W-1]};
  assign div_tr  = {1'b0, div_sh} - {2'b00, g_q};
  assign mul_sum = {1'b0, hi_q} + (a_q[0] ? {1'b0, b_q} : '0);

  // Advance the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      glu_pkg::ST_IDLE: begin
        if (start) state_d = glu_pkg::ST_GCD;
      end
      glu_pkg::ST_GCD: begin
        if (gcd_end) state_d = glu_pkg::ST_SCALE;
      end
      glu_pkg::ST_SCALE: begin
        if (k_q == '0) state_d = zero_q ? glu_pkg::ST_DONE : glu_pkg::ST_DIV;
      end
      glu_pkg::ST_DIV: begin
        if (cnt_q == '0) state_d = glu_pkg::ST_MUL;
      end
      glu_pkg::ST_MUL: begin
        if (cnt_q == '0) state_d = glu_pkg::ST_DONE;
      end
      glu_pkg::ST_DONE: begin
        state_d = glu_pkg::ST_IDLE;
      end
      default: state_d = glu_pkg::ST_IDLE;
    endcase
  end

  // Drive handshake outputs from the state.
  always_comb begin
    busy           = (state_q != glu_pkg::ST_IDLE);
    result_valid_o = (state_q == glu_pkg::ST_DONE);
  end

  // Hold the sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step the datapath one bit per cycle.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      glu_pkg::ST_IDLE: begin
        if (accept) begin
          a_q    <= value_a_i;
          b_q    <= value_b_i;
          x_q    <= value_a_i;
          y_q    <= value_b_i;
          k_q    <= '0;
          rem_q  <= '0;
          hi_q   <= '0;
          zero_q <= (value_a_i == '0) || (value_b_i == '0);
        end
      end
      glu_pkg::ST_GCD: begin
        if (gcd_end) begin
          g_q <= x_q | y_q;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + C'(1);
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (!diff_xy[W]) begin
          x_q <= {1'b0, diff_xy[W-1:1]};
        end else begin
          y_q <= {1'b0, diff_yx[W-1:1]};
        end
      end
      glu_pkg::ST_SCALE: begin
        // Restore the common powers of two, then clear the product on a zero operand.
        if (k_q != '0) begin
          g_q <= g_q << 1;
          k_q <= k_q - C'(1);
        end else begin
          cnt_q <= CntLast;
          if (zero_q) begin
            a_q  <= '0;
            hi_q <= '0;
          end
        end
      end
      glu_pkg::ST_DIV: begin
        // Restoring divide: shift quotient bits into a_q.
        if (!div_tr[W+1]) begin
          rem_q <= div_tr[W-1:0];
          a_q   <= {a_q[W-2:0], 1'b1};
        end else begin
          rem_q <= div_sh[W-1:0];
          a_q   <= {a_q[W-2:0], 1'b0};
        end
        cnt_q <= (cnt_q == '0) ? CntLast : cnt_q - C'(1);
      end
      glu_pkg::ST_MUL: begin
        // Shift-add multiply: product builds in {hi_q, a_q}.
        hi_q  <= mul_sum[W:1];
        a_q   <= {mul_sum[0], a_q[W-1:1]};
        cnt_q <= cnt_q - C'(1);
      end
      glu_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign gcd_out_o      = g_q;
  assign lcm_out_o      = a_q;
  assign lcm_overflow_o = |hi_q;

  // The unit is free again right after a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) result_valid_o |=> !busy)
    else $error("busy still high after result");

  // An accepted request starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("request accepted but unit not busy");

  // A zero gcd only ever comes with a zero lcm and no overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (gcd_out_o == '0) |-> (lcm_out_o == '0) && !lcm_overflow_o)
    else $error("nonzero lcm with zero gcd");

  // The divider never runs with a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == glu_pkg::ST_DIV) |-> (g_q != '0))
    else $error("divide by zero");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for gcd_lcm_unit: paced request driver, result monitor, watchdog.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned W = glu_pkg::Width;
  localparam int unsigned RandomRequests = 1400;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainCycles = 150;
  localparam longint unsigned OperandMax = (64'd1 << W) - 1;

  typedef struct packed {
    logic [W-1:0] a;
    logic [W-1:0] b;
  } operand_pair_t;

  typedef struct packed {
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] gcd;
    logic [W-1:0] lcm;
    logic         overflow;
  } gcd_lcm_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [W-1:0] value_a = '0;
  logic [W-1:0] value_b = '0;
  logic         result_valid;
  logic [W-1:0] gcd_out;
  logic [W-1:0] lcm_out;
  logic         lcm_overflow;

  operand_pair_t operand_q[$];
  gcd_lcm_t      gcd_lcm_q[$];
  int unsigned   fail_count = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;

  gcd_lcm_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_a_i      (value_a),
    .value_b_i      (value_b),
    .result_valid_o (result_valid),
    .gcd_out_o      (gcd_out),
    .lcm_out_o      (lcm_out),
    .lcm_overflow_o (lcm_overflow)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Euclid's remainder loop for the gcd, then lcm as (a / gcd) * b kept at full width
  function automatic gcd_lcm_t predict_gcd_lcm(input logic [W-1:0] a, input logic [W-1:0] b);
    longint unsigned x;
    longint unsigned y;
    longint unsigned rem;
    longint unsigned lcm_full;
    gcd_lcm_t        res;
    x = a;
    y = b;
    while (y != 0) begin
      rem = x % y;
      x = y;
      y = rem;
    end
    lcm_full = 0;
    if (a != 0 && b != 0) begin
      lcm_full = (longint'(a) / x) * longint'(b);
    end
    res.a = a;
    res.b = b;
    res.gcd = x[W-1:0];
    res.lcm = lcm_full[W-1:0];
    res.overflow = (lcm_full > OperandMax);
    return res;
  endfunction

  // Request driver: bursts of back-to-back requests separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic          next_start;
    logic [W-1:0]  next_a;
    logic [W-1:0]  next_b;
    operand_pair_t req;
    if (!rst_ni) begin
      start <= 1'b0;
      value_a <= '0;
      value_b <= '0;
    end else begin
      next_start = start;
      next_a = value_a;
      next_b = value_b;
      // record the accepted request and, when its burst ends, pick the pause that follows it
      if (start && !busy) begin
        gcd_lcm_q.push_back(predict_gcd_lcm(value_a, value_b));
        next_start = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
        end
      end
      // hold during a gap with junk on the operands, else present the next request
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
          next_a = W'($urandom);
          next_b = W'($urandom);
        end else if (operand_q.size() > 0) begin
          req = operand_q.pop_front();
          next_a = req.a;
          next_b = req.b;
          next_start = 1'b1;
        end
      end
      start <= next_start;
      value_a <= next_a;
      value_b <= next_b;
    end
  end

  // Result monitor: compare each strobe with the oldest prediction
  always @(posedge clk_i) begin : check_results
    gcd_lcm_t want;
    if (rst_ni && result_valid) begin
      if (gcd_lcm_q.size() == 0) begin
        $error("unexpected result: gcd %0d lcm %0d overflow %0d", gcd_out, lcm_out,
               lcm_overflow);
        fail_count++;
      end else begin
        want = gcd_lcm_q.pop_front();
        if (gcd_out !== want.gcd) begin
          $error("gcd_out (a=%0d b=%0d): expected %0d, got %0d", want.a, want.b, want.gcd,
                 gcd_out);
          fail_count++;
        end
        if (lcm_out !== want.lcm) begin
          $error("lcm_out (a=%0d b=%0d): expected %0d, got %0d", want.a, want.b, want.lcm,
                 lcm_out);
          fail_count++;
        end
        if (lcm_overflow !== want.overflow) begin
          $error("lcm_overflow (a=%0d b=%0d): expected %0d, got %0d", want.a, want.b,
                 want.overflow, lcm_overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: abort when neither a request nor a result moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("gcd_lcm_unit regression: fail");
        $finish;
      end
    end
  end

  // Load the request queue, release reset, drain and report
  initial begin : stimulus
    operand_pair_t p;
    int unsigned   g;
    int unsigned   k;
    logic [W-1:0]  directed_a[$];
    logic [W-1:0]  directed_b[$];
    // zeros, extremes, coprime and shared-factor pairs, lcm at and just past the top
    directed_a = '{0, 0, 37, 0, 65535, 1, 65535, 65535, 1, 65535, 32768, 32768, 12,
                   48, 65521, 255, 256, 255, 3, 2, 65534, 12345, 256, 1024};
    directed_b = '{0, 37, 0, 65535, 0, 1, 65535, 1, 65535, 65534, 32768, 16384, 18,
                   180, 65519, 256, 256, 257, 21845, 32768, 32767, 12345, 257, 40960};
    foreach (directed_a[i]) begin
      p.a = directed_a[i];
      p.b = directed_b[i];
      operand_q.push_back(p);
    end

    for (int n = 0; n < RandomRequests; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          p.a = W'($urandom);
          p.b = W'($urandom);
        end
        3, 4: begin
          // shared factor of 1 to 255, so the gcd is a multiple of it
          g = $urandom_range(1, 255);
          p.a = W'(g * $urandom_range(1, 65535 / g));
          p.b = W'(g * $urandom_range(1, 65535 / g));
        end
        5: begin
          // shifts of up to 8 bits, so the operands often share powers of two
          p.a = W'($urandom_range(1, 255) << $urandom_range(0, 8));
          p.b = W'($urandom_range(1, 255) << $urandom_range(0, 8));
        end
        6: begin
          p.a = W'($urandom_range(0, 300));
          p.b = W'($urandom_range(0, 300));
        end
        7: begin
          p.a = W'($urandom);
          p.b = '0;
          if ($urandom_range(0, 1) == 1) begin
            p.b = p.a;
            p.a = '0;
          end
        end
        8: begin
          // one operand a multiple of the other
          g = $urandom_range(1, 65535);
          k = $urandom_range(1, 65535 / g);
          p.a = W'(g);
          p.b = W'(g * k);
        end
        default: begin
          p.a = W'(65535 - $urandom_range(0, 255));
          p.b = W'($urandom_range(32768, 65535));
        end
      endcase
      operand_q.push_back(p);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (operand_q.size() != 0 || start || gcd_lcm_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("gcd_lcm_unit regression: pass");
    end else begin
      $display("gcd_lcm_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/glu_pkg.sv
rtl/gcd_lcm_unit.sv
tb/tb_top.sv
